// ===== src/sprite_frame_index_select_macros.svh =====
// Assertion macros for the sprite frame index select block
`ifndef SPRITE_FRAME_INDEX_SELECT_MACROS_SVH
`define SPRITE_FRAME_INDEX_SELECT_MACROS_SVH

`ifndef SYNTHESIS
`define SFIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfis check failed");
`define SFIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfis check failed");
`else
`define SFIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/sfis_pkg.sv =====
// Types, constants and helpers shared by the sprite frame index select block
`timescale 1ns / 1ps
package sfis_pkg;

    localparam int TICK_W   = 64;
    localparam int HASH_W   = 64;
    localparam int ID_W     = 32;
    localparam int MS_W     = 16;
    localparam int FPS_W    = 10;
    localparam int MODE_W   = 3;
    localparam int N_W      = 11;
    localparam int PER_W    = 12;
    localparam int FI_W     = 10;
    localparam int PROD_W   = 26;
    localparam int STEP_W   = 17;
    localparam int RCP_W    = 27;
    localparam int SCALED_W = PROD_W + RCP_W;
    localparam int RCP_SH   = 36;
    localparam int REQ_W    = 3 * ID_W + 3 * TICK_W + 1 + FPS_W;
    localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + FI_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_FRAMES = 1024;

    localparam logic [HASH_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [PROD_W-1:0] ROUND_UP   = 26'd999;
    // ceil(2^36 / 1000): exact quotient by 1000 for 26-bit dividends
    localparam logic [RCP_W-1:0]  RECIP_1000 = 27'd68719477;

    localparam logic [MODE_W-1:0] MODE_LOOP       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ONCE_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOP_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PP         = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PP_BACK    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_START = 2'd3;

    typedef struct packed {
        logic [TICK_W-1:0] current_tick;
        logic [FPS_W-1:0]  ticks_per_second;
        logic              permanent;
        logic [TICK_W-1:0] last_visible_tick;
        logic [TICK_W-1:0] start_tick;
        logic [ID_W-1:0]   sequence_req;
        logic [ID_W-1:0]   epoch;
        logic [ID_W-1:0]   object_id;
    } t_req;

    typedef struct packed {
        logic [N_W-1:0]    n;
        logic [MODE_W-1:0] mode;
        logic [MS_W-1:0]   delay_ms;
        logic              random_start;
    } t_cfg;

    // FNV-1a round; prime is 2^40 + 0x1B3
    function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] p);
        logic [HASH_W-1:0] x;
        x = h ^ p;
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== src/sfis_front.sv =====
// Front stages: visibility, elapsed ticks, step length and start-frame hash
`timescale 1ns / 1ps
module sfis_front import sfis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_req              i_req,
    input  t_cfg              i_cfg,
    output logic              o_valid,
    output logic              o_visible,
    output logic [TICK_W-1:0] o_elapsed,
    output logic [STEP_W-1:0] o_step,
    output logic [HASH_W-1:0] o_hash
);

    logic [3:0] r_vld;

    logic              r1_vis, r1_zero_ms;
    logic [TICK_W-1:0] r1_elapsed, r1_start;
    logic [PROD_W-1:0] r1_prod;
    logic [HASH_W-1:0] r1_h;
    logic [ID_W-1:0]   r1_ep, r1_seq;

    logic                r2_vis, r2_zero_ms;
    logic [TICK_W-1:0]   r2_elapsed, r2_start;
    logic [SCALED_W-1:0] r2_scaled;
    logic [HASH_W-1:0]   r2_h;
    logic [ID_W-1:0]     r2_seq;

    logic              r3_vis;
    logic [TICK_W-1:0] r3_elapsed, r3_start;
    logic [STEP_W-1:0] r3_step;
    logic [HASH_W-1:0] r3_h;

    logic              r4_vis;
    logic [TICK_W-1:0] r4_elapsed;
    logic [STEP_W-1:0] r4_step;
    logic [HASH_W-1:0] r4_h;

    logic                n1_vis;
    logic [FPS_W-1:0]    n1_rate;
    logic [PROD_W-1:0]   n2_sum;
    logic [SCALED_W-1:0] n2_scaled;
    logic [STEP_W-1:0]   n3_q;
    logic [STEP_W-1:0]   n3_step;

    assign n1_vis = (i_cfg.n != '0) && (i_req.current_tick >= i_req.start_tick)
                  && (i_req.permanent || (i_req.current_tick <= i_req.last_visible_tick));
    assign n1_rate = (i_req.ticks_per_second == '0) ? FPS_W'(1) : i_req.ticks_per_second;
    assign n2_sum = r1_prod + ROUND_UP;
    assign n2_scaled = n2_sum * RECIP_1000;
    assign n3_q = r2_scaled[RCP_SH +: STEP_W];
    assign n3_step = (r2_zero_ms || (n3_q == '0)) ? STEP_W'(1) : n3_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vis     <= n1_vis;
            r1_zero_ms <= (i_cfg.delay_ms == '0);
            r1_elapsed <= i_req.current_tick - i_req.start_tick;
            r1_start   <= i_req.start_tick;
            r1_prod    <= PROD_W'(i_cfg.delay_ms) * PROD_W'(n1_rate);
            r1_h       <= fnv_mix(HASH_BASIS, HASH_W'(i_req.object_id));
            r1_ep      <= i_req.epoch;
            r1_seq     <= i_req.sequence_req;

            r2_vis     <= r1_vis;
            r2_zero_ms <= r1_zero_ms;
            r2_elapsed <= r1_elapsed;
            r2_start   <= r1_start;
            r2_scaled  <= n2_scaled;
            r2_h       <= fnv_mix(r1_h, HASH_W'(r1_ep));
            r2_seq     <= r1_seq;

            r3_vis     <= r2_vis;
            r3_elapsed <= r2_elapsed;
            r3_start   <= r2_start;
            r3_step    <= n3_step;
            r3_h       <= fnv_mix(r2_h, HASH_W'(r2_seq));

            r4_vis     <= r3_vis;
            r4_elapsed <= r3_elapsed;
            r4_step    <= r3_step;
            r4_h       <= fnv_mix(r3_h, r3_start);
        end
    end

    assign o_valid   = r_vld[3];
    assign o_visible = r4_vis;
    assign o_elapsed = r4_elapsed;
    assign o_step    = r4_step;
    assign o_hash    = r4_h;

endmodule

// ===== src/sfis_div_pipe.sv =====
// Pipelined restoring divider, BPS quotient bits per stage, with side payload
`timescale 1ns / 1ps
`include "sprite_frame_index_select_macros.svh"
module sfis_div_pipe import sfis_pkg::*; #(
    parameter int DW  = 64,
    parameter int VW  = 17,
    parameter int BPS = 4,
    parameter int PW  = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic [PW-1:0] o_side
);

    localparam int NS = DW / BPS;

    logic [NS-1:0] r_vld;
    logic [DW-1:0] r_num  [NS];
    logic [VW-1:0] r_rem  [NS];
    logic [VW-1:0] r_den  [NS];
    logic [PW-1:0] r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] num_in;
        logic [VW-1:0] rem_in;
        logic [VW-1:0] den_in;
        logic [PW-1:0] side_in;
        logic [DW-1:0] n_num;
        logic [VW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[s-1];
            assign num_in  = r_num[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        // dividend shifts out at the top, quotient bits shift in at the bottom
        always_comb begin : p_step
            logic [VW:0] t;
            n_num = num_in;
            n_rem = rem_in;
            for (int b = 0; b < BPS; b++) begin
                t     = {n_rem, n_num[DW-1]};
                n_num = {n_num[DW-2:0], 1'b0};
                if (t >= {1'b0, den_in}) begin
                    t        = t - {1'b0, den_in};
                    n_num[0] = 1'b1;
                end
                n_rem = t[VW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s]  <= n_num;
                r_rem[s]  <= n_rem;
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_num[NS-1];
    assign o_rem   = r_rem[NS-1];
    assign o_side  = r_side[NS-1];

    `SFIS_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_vld[NS-1] && (r_den[NS-1] != '0), r_rem[NS-1] < r_den[NS-1])
    `SFIS_ASSERT_NXT(a_stall_holds_valids, i_clk, i_rst_n, !i_en, $stable(r_vld))

endmodule

// ===== src/sfis_select.sv =====
// Final stage: start frame and per-mode frame walk, output register
`timescale 1ns / 1ps
`include "sprite_frame_index_select_macros.svh"
module sfis_select import sfis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_visible,
    input  t_cfg              i_cfg,
    input  logic [PER_W-1:0]  i_period,
    input  logic [N_W-1:0]    i_hmod,
    input  logic [TICK_W-1:0] i_steps,
    input  logic [N_W-1:0]    i_smod_n,
    input  logic [PER_W-1:0]  i_smod_p,
    output logic              o_valid,
    output logic              o_visible,
    output logic [FI_W-1:0]   o_frame
);

    logic            r_valid;
    logic            r_visible;
    logic [FI_W-1:0] r_frame;
    logic [N_W-1:0]  n_frame;

    always_comb begin : p_frame
        logic [N_W-1:0]   init;
        logic [N_W-1:0]   last_idx;
        logic [N_W-1:0]   to_end;
        logic [N_W:0]     sum_n;
        logic [PER_W:0]   ph;
        logic [PER_W:0]   per;
        logic             backwards;
        backwards = (i_cfg.mode == MODE_ONCE_BACK) || (i_cfg.mode == MODE_LOOP_BACK)
                 || (i_cfg.mode == MODE_PP_BACK);
        last_idx = i_cfg.n - N_W'(1);
        if (i_cfg.random_start) begin
            init = i_hmod;
        end else if (backwards) begin
            init = last_idx;
        end else begin
            init = '0;
        end
        to_end = last_idx - init;
        per    = {1'b0, i_period};
        sum_n  = '0;
        ph     = '0;
        n_frame = init;
        case (i_cfg.mode) inside
            MODE_ONCE: begin
                n_frame = (i_steps >= TICK_W'(to_end)) ? last_idx : init + i_steps[N_W-1:0];
            end
            MODE_ONCE_BACK: begin
                n_frame = (i_steps >= TICK_W'(init)) ? '0 : init - i_steps[N_W-1:0];
            end
            MODE_LOOP_BACK: begin
                sum_n = {1'b0, init} + {1'b0, i_cfg.n} - {1'b0, i_smod_n};
                if (sum_n >= {1'b0, i_cfg.n}) begin
                    sum_n = sum_n - {1'b0, i_cfg.n};
                end
                n_frame = sum_n[N_W-1:0];
            end
            MODE_PP, MODE_PP_BACK: begin
                if (i_cfg.n > N_W'(1)) begin
                    if (i_cfg.mode == MODE_PP) begin
                        ph = {2'b0, init} + {1'b0, i_smod_p};
                    end else begin
                        ph = {2'b0, init} + per - {1'b0, i_smod_p};
                    end
                    if (ph >= per) begin
                        ph = ph - per;
                    end
                    n_frame = (ph < {2'b0, i_cfg.n}) ? ph[N_W-1:0] : N_W'(per - ph);
                end
            end
            default: begin
                sum_n = {1'b0, init} + {1'b0, i_smod_n};
                if (sum_n >= {1'b0, i_cfg.n}) begin
                    sum_n = sum_n - {1'b0, i_cfg.n};
                end
                n_frame = sum_n[N_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_visible <= i_visible;
            r_frame   <= i_visible ? n_frame[FI_W-1:0] : '0;
        end
    end

    assign o_valid   = r_valid;
    assign o_visible = r_visible;
    assign o_frame   = r_frame;

    `SFIS_ASSERT_IMP(a_hidden_frame_zero, i_clk, i_rst_n, r_valid && !r_visible, r_frame == '0)
    `SFIS_ASSERT_IMP(a_frame_in_range, i_clk, i_rst_n, r_valid && r_visible, N_W'(r_frame) < i_cfg.n)

endmodule

// ===== src/sprite_frame_index_select.sv =====
// Top level of the sprite animation frame index select pipeline
//
//  Port group   Dir  Payload
//  s_axis       in   tdata: object_id, epoch, sequence_req, start_tick,
//                           last_visible_tick, permanent, ticks_per_second, current_tick
//  m_axis       out  tdata: visible, frame_index
//  cfg          in   write enable, index, 16-bit data
//
//  One transaction per cycle except while the pipeline holds; 4 front stages, two 16-stage
//  divider layers at 4 quotient bits per stage, one output register.
//  The two chained 64-bit divisions set the depth.
//  Reset clears configuration and all stage valid bits.
//  The whole pipeline holds while a result waits in the output register.
`timescale 1ns / 1ps
module sprite_frame_index_select import sfis_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // object_id, epoch, sequence_req, start_tick, last_visible_tick, permanent,
    // ticks_per_second, current_tick, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // visible, frame_index, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DIV_BPS = 4;
    localparam int SIDE_W  = 1 + N_W + TICK_W;

    logic [N_W-1:0]    r_frame_count;
    logic [MODE_W-1:0] r_anim_mode;
    logic [MS_W-1:0]   r_delay_ms;
    logic              r_random_start;

    logic              w_en;
    t_req              w_req;
    t_cfg              w_cfg;
    logic [PER_W-1:0]  w_period;

    logic              f_valid, f_vis;
    logic [TICK_W-1:0] f_elapsed;
    logic [STEP_W-1:0] f_step;
    logic [HASH_W-1:0] f_hash;

    logic              a_valid;
    logic [TICK_W-1:0] a_steps;
    logic              a_vis;
    logic [N_W-1:0]    b_rem;

    logic              c_valid;
    logic [N_W-1:0]    c_rem;
    logic [SIDE_W-1:0] c_side;
    logic [PER_W-1:0]  d_rem;

    logic              s_valid, s_visible;
    logic [FI_W-1:0]   s_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= '0;
            r_anim_mode    <= '0;
            r_delay_ms     <= '0;
            r_random_start <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[N_W-1:0];
                CFG_ANIM_MODE:    r_anim_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_DELAY_MS:     r_delay_ms     <= i_cfg_data[MS_W-1:0];
                CFG_RANDOM_START: r_random_start <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_cfg.n = (32'(r_frame_count) > MAX_FRAMES) ? N_W'(MAX_FRAMES) : r_frame_count;
    assign w_cfg.mode = r_anim_mode;
    assign w_cfg.delay_ms = r_delay_ms;
    assign w_cfg.random_start = r_random_start;
    assign w_period = {w_cfg.n - N_W'(1), 1'b0};

    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_req = t_req'(i_s_axis_tdata[REQ_W-1:0]);

    sfis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_req     (w_req),
        .i_cfg     (w_cfg),
        .o_valid   (f_valid),
        .o_visible (f_vis),
        .o_elapsed (f_elapsed),
        .o_step    (f_step),
        .o_hash    (f_hash)
    );

    sfis_div_pipe #(.DW(TICK_W), .VW(STEP_W), .BPS(DIV_BPS), .PW(1)) u_div_steps (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_num   (f_elapsed),
        .i_den   (f_step),
        .i_side  (f_vis),
        .o_valid (a_valid),
        .o_quo   (a_steps),
        .o_rem   (),
        .o_side  (a_vis)
    );

    sfis_div_pipe #(.DW(HASH_W), .VW(N_W), .BPS(DIV_BPS), .PW(1)) u_div_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_num   (f_hash),
        .i_den   (w_cfg.n),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (),
        .o_rem   (b_rem),
        .o_side  ()
    );

    sfis_div_pipe #(.DW(TICK_W), .VW(N_W), .BPS(DIV_BPS), .PW(SIDE_W)) u_div_mod_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (a_valid),
        .i_num   (a_steps),
        .i_den   (w_cfg.n),
        .i_side  ({a_vis, b_rem, a_steps}),
        .o_valid (c_valid),
        .o_quo   (),
        .o_rem   (c_rem),
        .o_side  (c_side)
    );

    sfis_div_pipe #(.DW(TICK_W), .VW(PER_W), .BPS(DIV_BPS), .PW(1)) u_div_mod_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (a_valid),
        .i_num   (a_steps),
        .i_den   (w_period),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (),
        .o_rem   (d_rem),
        .o_side  ()
    );

    sfis_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (c_valid),
        .i_visible (c_side[SIDE_W-1]),
        .i_cfg     (w_cfg),
        .i_period  (w_period),
        .i_hmod    (c_side[TICK_W +: N_W]),
        .i_steps   (c_side[TICK_W-1:0]),
        .i_smod_n  (c_rem),
        .i_smod_p  (d_rem),
        .o_valid   (s_valid),
        .o_visible (s_visible),
        .o_frame   (s_frame)
    );

    assign o_m_axis_tvalid = s_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 1 - FI_W){1'b0}}, s_frame, s_visible};

endmodule
